>>> rtl/bsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants of the bank switch mapper: item layouts,
// register indexes, decode addresses and internal operation codes.
// ----------------------------------------------------------------------------
package bsm_pkg;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADDRESS_MASK   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_PAGE_COUNT = 1'b1;

   localparam logic [15:0] ADDR_MASK_RESET  = 16'hFFFF;
   localparam logic [8:0]  PAGE_COUNT_RESET = 9'd16;

   // character bank registers
   localparam int CHR_SLOTS = 8;
   localparam int CHR_IDX_W = $clog2(CHR_SLOTS);

   // item commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TICK  = 1'b1;

   // decode addresses (after masking)
   localparam logic [3:0]  HI_PRG_A      = 4'h8;
   localparam logic [3:0]  HI_PRG_B      = 4'hA;
   localparam logic [3:0]  HI_CHR_FIRST  = 4'hB;
   localparam logic [3:0]  HI_CHR_LAST   = 4'hE;
   localparam logic [11:0] PRG_LO_MASK   = 12'h00C;
   localparam logic [15:0] ADDR_MIRROR   = 16'h9000;
   localparam logic [15:0] ADDR_SWAP     = 16'h9008;
   localparam logic [15:0] ADDR_LATCH_LO = 16'hF000;
   localparam logic [15:0] ADDR_LATCH_HI = 16'hF004;
   localparam logic [15:0] ADDR_IRQ_CTRL = 16'hF008;
   localparam logic [15:0] ADDR_IRQ_ACK  = 16'hF00C;

   localparam logic [7:0] MIRROR_IGNORE = 8'hFF;
   localparam logic [7:0] COUNT_MAX     = 8'hFF;

   // bank slots
   localparam logic [3:0] SLOT_PRG0     = 4'd0;
   localparam logic [3:0] SLOT_PRG1     = 4'd1;
   localparam logic [3:0] SLOT_PRG2     = 4'd2;
   localparam logic [3:0] SLOT_CHR_BASE = 4'd4;

   // operation codes passed from front to back
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
   localparam logic [OP_W-1:0] OP_TICK     = 4'd1;
   localparam logic [OP_W-1:0] OP_PRG_A    = 4'd2;
   localparam logic [OP_W-1:0] OP_PRG_B    = 4'd3;
   localparam logic [OP_W-1:0] OP_MIRROR   = 4'd4;
   localparam logic [OP_W-1:0] OP_SWAP     = 4'd5;
   localparam logic [OP_W-1:0] OP_CHR      = 4'd6;
   localparam logic [OP_W-1:0] OP_LATCH_LO = 4'd7;
   localparam logic [OP_W-1:0] OP_LATCH_HI = 4'd8;
   localparam logic [OP_W-1:0] OP_IRQ_CTRL = 4'd9;
   localparam logic [OP_W-1:0] OP_IRQ_ACK  = 4'd10;

   // remainder unit
   localparam int MOD_BITS           = 8;
   localparam int MOD_BITS_PER_CYCLE = 2;
   localparam int MOD_CYCLES         = MOD_BITS / MOD_BITS_PER_CYCLE;

   typedef struct packed {
      logic        cmd;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic       bank_update;
      logic [3:0] bank_slot;
      logic [7:0] bank_page;
      logic       mirror_update;
      logic [1:0] mirror_mode;
      logic       irq_request;
   } rsp_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [7:0]           data;
      logic [CHR_IDX_W-1:0] chr_idx;
      logic                 chr_high;
   } op_type;

   typedef struct packed {
      logic                start;
      logic [MOD_BITS-1:0] dividend;
      logic [MOD_BITS-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic                done;
      logic [MOD_BITS-1:0] remainder;
   } mod_rsp_type;

endpackage
`default_nettype wire

>>> rtl/bsm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_front
// Masks the write address and classifies each item into an operation for
// the back end.
// ----------------------------------------------------------------------------
module bsm_front (
   input  wire  bsm_pkg::req_type req_data,
   input  logic [15:0]            address_mask,
   output bsm_pkg::op_type        op_out
);

   logic [15:0] addr;
   logic [3:0]  hi;
   logic [11:0] lo;
   logic [3:0]  chr_pair;
   logic        prg_lo_ok;
   logic        chr_odd;
   logic        chr_high;
   logic        chr_hit;

   assign addr      = req_data.address & address_mask;
   assign hi        = addr[15:12];
   assign lo        = addr[11:0];
   assign prg_lo_ok = (lo & ~bsm_pkg::PRG_LO_MASK) == 12'h000;
   assign chr_pair  = hi - bsm_pkg::HI_CHR_FIRST;

   // character nibble offset decode
   always_comb begin
      chr_hit  = 1'b1;
      chr_odd  = 1'b0;
      chr_high = 1'b0;
      case (lo) inside
         12'h000: begin
            chr_odd  = 1'b0;
            chr_high = 1'b0;
         end
         12'h001, 12'h004: begin
            chr_odd  = 1'b0;
            chr_high = 1'b1;
         end
         12'h002, 12'h008: begin
            chr_odd  = 1'b1;
            chr_high = 1'b0;
         end
         12'h003, 12'h00C: begin
            chr_odd  = 1'b1;
            chr_high = 1'b1;
         end
         default: begin
            chr_hit = 1'b0;
         end
      endcase
   end

   // classify the item
   always_comb begin
      op_out.op       = bsm_pkg::OP_NONE;
      op_out.data     = req_data.write_data;
      op_out.chr_idx  = {chr_pair[1:0], chr_odd};
      op_out.chr_high = chr_high;
      if (req_data.cmd == bsm_pkg::CMD_TICK) begin
         op_out.op = bsm_pkg::OP_TICK;
      end else if (hi == bsm_pkg::HI_PRG_A && prg_lo_ok) begin
         op_out.op = bsm_pkg::OP_PRG_A;
      end else if (hi == bsm_pkg::HI_PRG_B && prg_lo_ok) begin
         op_out.op = bsm_pkg::OP_PRG_B;
      end else if (addr == bsm_pkg::ADDR_MIRROR) begin
         // data of all ones leaves mirroring alone
         if (req_data.write_data != bsm_pkg::MIRROR_IGNORE) begin
            op_out.op = bsm_pkg::OP_MIRROR;
         end
      end else if (addr == bsm_pkg::ADDR_SWAP) begin
         op_out.op = bsm_pkg::OP_SWAP;
      end else if (hi inside {[bsm_pkg::HI_CHR_FIRST:bsm_pkg::HI_CHR_LAST]}) begin
         if (chr_hit) begin
            op_out.op = bsm_pkg::OP_CHR;
         end
      end else if (addr == bsm_pkg::ADDR_LATCH_LO) begin
         op_out.op = bsm_pkg::OP_LATCH_LO;
      end else if (addr == bsm_pkg::ADDR_LATCH_HI) begin
         op_out.op = bsm_pkg::OP_LATCH_HI;
      end else if (addr == bsm_pkg::ADDR_IRQ_CTRL) begin
         op_out.op = bsm_pkg::OP_IRQ_CTRL;
      end else if (addr == bsm_pkg::ADDR_IRQ_ACK) begin
         op_out.op = bsm_pkg::OP_IRQ_ACK;
      end
   end

endmodule
`default_nettype wire

>>> rtl/bsm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_queue
// Short first-in first-out queue of classified operations between the
// front and the back end.
// ----------------------------------------------------------------------------
module bsm_queue #(
   parameter int DEPTH = 2
) (
   input  wire  clock,
   input  wire  reset,
   input  logic                  push,
   input  bsm_pkg::op_type       push_data,
   output logic                  full,
   output logic                  not_empty,
   input  logic                  pop,
   output bsm_pkg::op_type       pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   bsm_pkg::op_type  entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = count_ff == CNT_FULL;
   assign not_empty = count_ff != '0;
   assign pop_data  = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> rtl/bsm_prg_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_prg_mod
// Restoring remainder unit for the program page select, two dividend bits
// per cycle.
// ----------------------------------------------------------------------------
module bsm_prg_mod (
   input  wire  clock,
   input  wire  reset,
   input  bsm_pkg::mod_req_type mod_req,
   output bsm_pkg::mod_rsp_type mod_rsp
);

   localparam int W     = bsm_pkg::MOD_BITS;
   localparam int STEPS = bsm_pkg::MOD_BITS_PER_CYCLE;
   localparam int CNT_W = (bsm_pkg::MOD_CYCLES > 1) ? $clog2(bsm_pkg::MOD_CYCLES) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(bsm_pkg::MOD_CYCLES - 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dvd_ff, dvd_in;
   logic [W-1:0]     dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   // one shift and conditional subtract
   function automatic logic [W-1:0] rem_step(input logic [W-1:0] rem,
                                             input logic bit_in,
                                             input logic [W-1:0] dvs);
      logic [W:0] trial;
      trial = {rem, bit_in};
      if (trial >= {1'b0, dvs}) begin
         trial = trial - {1'b0, dvs};
      end
      return trial[W-1:0];
   endfunction

   // steps of this cycle
   always_comb begin
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      for (int s = 0; s < STEPS; s++) begin
         rem_in = rem_step(rem_in, dvd_in[W-1], dvs_ff);
         dvd_in = {dvd_in[W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (mod_req.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (mod_req.start) begin
         rem_ff <= '0;
         dvd_ff <= mod_req.dividend;
         dvs_ff <= mod_req.divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule
`default_nettype wire

>>> rtl/bsm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_back
// Carries out classified operations: holds the bank, swap and IRQ state,
// runs the page select remainder and drives the result register.
// ----------------------------------------------------------------------------
module bsm_back (
   input  wire  clock,
   input  wire  reset,
   input  logic [8:0]            prg_page_count,
   input  logic                  q_valid,
   input  bsm_pkg::op_type       q_data,
   output logic                  q_pop,
   output bsm_pkg::mod_req_type  mod_req,
   input  bsm_pkg::mod_rsp_type  mod_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bsm_pkg::rsp_type      rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_MOD  = 1'b1;

   logic             state_ff, state_in;
   logic             swap_ff, swap_in;
   logic [1:0]       irq_en_ff, irq_en_in;
   logic [7:0]       irq_count_ff, irq_count_in;
   logic [7:0]       irq_reload_ff, irq_reload_in;
   logic [3:0]       slot_ff, slot_in;
   logic [7:0]       chr_ff [bsm_pkg::CHR_SLOTS];
   logic             chr_wr;
   logic [7:0]       chr_cur;
   logic [7:0]       chr_new;
   logic             rsp_valid_ff, rsp_valid_in;
   bsm_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_load;
   logic             out_free;
   logic             take;
   logic             prg_direct;
   logic [3:0]       prg_slot;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign take       = (state_ff == ST_IDLE) && q_valid && out_free;
   assign q_pop      = take;
   assign prg_direct = (prg_page_count == 9'd0) || prg_page_count[8];
   assign chr_cur    = chr_ff[q_data.chr_idx];
   assign chr_new    = q_data.chr_high ? {q_data.data[3:0], chr_cur[3:0]}
                                       : {chr_cur[7:4], q_data.data[3:0]};
   assign prg_slot   = (q_data.op == bsm_pkg::OP_PRG_B) ? bsm_pkg::SLOT_PRG1 :
                       (swap_ff ? bsm_pkg::SLOT_PRG2 : bsm_pkg::SLOT_PRG0);

   // operation execution
   always_comb begin
      state_in         = state_ff;
      swap_in          = swap_ff;
      irq_en_in        = irq_en_ff;
      irq_count_in     = irq_count_ff;
      irq_reload_in    = irq_reload_ff;
      slot_in          = slot_ff;
      chr_wr           = 1'b0;
      rsp_load         = 1'b0;
      rsp_in           = '0;
      mod_req.start    = 1'b0;
      mod_req.dividend = q_data.data;
      mod_req.divisor  = prg_page_count[7:0];
      if (take) begin
         rsp_load = 1'b1;
         case (q_data.op)
            bsm_pkg::OP_TICK: begin
               if (irq_en_ff[1]) begin
                  if (irq_count_ff == bsm_pkg::COUNT_MAX) begin
                     irq_count_in       = irq_reload_ff;
                     irq_en_in          = {irq_en_ff[0], irq_en_ff[0]};
                     rsp_in.irq_request = 1'b1;
                  end else begin
                     irq_count_in = irq_count_ff + 8'd1;
                  end
               end
            end
            bsm_pkg::OP_PRG_A, bsm_pkg::OP_PRG_B: begin
               if (prg_direct) begin
                  rsp_in.bank_update = 1'b1;
                  rsp_in.bank_slot   = prg_slot;
                  rsp_in.bank_page   = q_data.data;
               end else begin
                  // result comes later from the remainder unit
                  rsp_load      = 1'b0;
                  mod_req.start = 1'b1;
                  slot_in       = prg_slot;
                  state_in      = ST_MOD;
               end
            end
            bsm_pkg::OP_MIRROR: begin
               rsp_in.mirror_update = 1'b1;
               rsp_in.mirror_mode   = q_data.data[1:0];
            end
            bsm_pkg::OP_SWAP: begin
               swap_in = q_data.data[1];
            end
            bsm_pkg::OP_CHR: begin
               chr_wr             = 1'b1;
               rsp_in.bank_update = 1'b1;
               rsp_in.bank_slot   = bsm_pkg::SLOT_CHR_BASE + {1'b0, q_data.chr_idx};
               rsp_in.bank_page   = chr_new;
            end
            bsm_pkg::OP_LATCH_LO: begin
               irq_reload_in = {irq_reload_ff[7:4], q_data.data[3:0]};
            end
            bsm_pkg::OP_LATCH_HI: begin
               irq_reload_in = {q_data.data[3:0], irq_reload_ff[3:0]};
            end
            bsm_pkg::OP_IRQ_CTRL: begin
               irq_en_in = q_data.data[1:0];
               if (q_data.data[1]) begin
                  irq_count_in = irq_reload_ff;
               end
            end
            bsm_pkg::OP_IRQ_ACK: begin
               irq_en_in = {irq_en_ff[0], irq_en_ff[0]};
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end else if (state_ff == ST_MOD && mod_rsp.done && out_free) begin
         rsp_load           = 1'b1;
         rsp_in.bank_update = 1'b1;
         rsp_in.bank_slot   = slot_ff;
         rsp_in.bank_page   = mod_rsp.remainder;
         state_in           = ST_IDLE;
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         swap_ff       <= 1'b0;
         irq_en_ff     <= 2'b00;
         irq_count_ff  <= 8'd0;
         irq_reload_ff <= 8'd0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++) begin
            chr_ff[i] <= 8'(i);
         end
      end else begin
         state_ff      <= state_in;
         swap_ff       <= swap_in;
         irq_en_ff     <= irq_en_in;
         irq_count_ff  <= irq_count_in;
         irq_reload_ff <= irq_reload_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (chr_wr) begin
            chr_ff[q_data.chr_idx] <= chr_new;
         end
      end
   end

   // result payload and pending slot
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/bank_switch_mapper_with_scanline_irq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bank_switch_mapper_with_scanline_irq
// Bank switching mapper with scanline interrupt counter.
//
// Items enter on req_ (valid/ready): a CPU register write or a scanline
// tick. Each item gives exactly one item on rsp_ (valid/ready) carrying
// bank, mirroring and interrupt updates. csr_ writes the address mask
// (index 0) and the program page count (index 1); the user writes them
// only while the block is idle, which the block itself does not enforce.
// The front decodes an item in its accept cycle into a queue; the back end
// takes one operation per cycle from the queue into the result register
// while that register is free and no remainder is pending.
// A program select whose page count lies in 1..255 runs the two bit per
// cycle remainder unit and holds the back end until the remainder is done.
// A stalled result register holds its item; the queue keeps accepting
// until it is full, then req_ready drops.
// Reset clears the queue, the result register, the IRQ state and the swap
// flag, and loads character bank i with page i.
// ----------------------------------------------------------------------------
module bank_switch_mapper_with_scanline_irq #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire  clock,
   input  wire  reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bsm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bsm_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_write_en,
   input  logic [bsm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bsm_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   logic [15:0]          address_mask_ff;
   logic [8:0]           page_count_ff;
   bsm_pkg::op_type      front_op;
   bsm_pkg::op_type      q_data;
   logic                 q_full;
   logic                 q_valid;
   logic                 q_pop;
   logic                 q_push;
   bsm_pkg::mod_req_type mod_req;
   bsm_pkg::mod_rsp_type mod_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         address_mask_ff <= bsm_pkg::ADDR_MASK_RESET;
         page_count_ff   <= bsm_pkg::PAGE_COUNT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            bsm_pkg::CSR_ADDRESS_MASK:   address_mask_ff <= csr_write_data[15:0];
            bsm_pkg::CSR_PRG_PAGE_COUNT: page_count_ff   <= csr_write_data[8:0];
            default: begin
               address_mask_ff <= address_mask_ff;
            end
         endcase
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   bsm_front u_front (
      .req_data     (req_data),
      .address_mask (address_mask_ff),
      .op_out       (front_op)
   );

   bsm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_op),
      .full      (q_full),
      .not_empty (q_valid),
      .pop       (q_pop),
      .pop_data  (q_data)
   );

   bsm_prg_mod u_prg_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   bsm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .prg_page_count (page_count_ff),
      .q_valid        (q_valid),
      .q_data         (q_data),
      .q_pop          (q_pop),
      .mod_req        (mod_req),
      .mod_rsp        (mod_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule
`default_nettype wire

>>> rtl/bsm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_checker
// Port level checks of the bank switch mapper, bound to the top level.
// ----------------------------------------------------------------------------
module bsm_checker (
   input  wire  clock,
   input  wire  reset,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  bsm_pkg::rsp_type rsp_data
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // no result item straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // bank fields are zero unless a slot was changed
   a_bank_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.bank_update |->
         rsp_data.bank_slot == 4'd0 && rsp_data.bank_page == 8'd0)
      else $error("bank fields set without a bank update");

   // an item causes at most one kind of update
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.bank_update, rsp_data.mirror_update,
                                rsp_data.irq_request}) <= 1)
      else $error("more than one kind of update in one item");

   // reported slots stay within the twelve slots
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bank_update |-> rsp_data.bank_slot <= 4'd11)
      else $error("bank slot out of range");

endmodule

bind bank_switch_mapper_with_scanline_irq bsm_checker u_bsm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
